[src/der_tlv_header_walker_unit_macros.svh]
// Assertion macros for the DER TLV header walker.
// Used by the top level only; needs clk and rst_n in scope.
`ifndef DER_TLV_HEADER_WALKER_UNIT_MACROS_SVH
`define DER_TLV_HEADER_WALKER_UNIT_MACROS_SVH

// Plain property, checked at every clock edge outside reset.
`define DTW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication form: antecedent holds, consequent holds in the same cycle.
`define DTW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[src/dtw_pkg.sv]
// Package for the DER TLV header walker: types, status and phase codes.
// No dependencies.
`timescale 1ns / 1ps
package dtw_pkg;

  localparam int DefStackDepth = 8;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_MALFORMED = 3'd1,
    ST_OVERRUN   = 3'd2,
    ST_STACK     = 3'd3,
    ST_TRUNC     = 3'd4
  } dtw_status_t;

  typedef enum logic [2:0] {
    P_IDLE,
    P_ID,
    P_TAG,
    P_LEN,
    P_LENX,
    P_SKIP
  } dtw_phase_t;

  typedef enum logic [1:0] {
    C_RUN,
    C_POPA,
    C_POPB
  } dtw_ctl_t;

  localparam logic [4:0] HighTagMark = 5'h1f;
  localparam logic [4:0] TagSequence = 5'h10;
  localparam logic [4:0] TagSet      = 5'h11;

endpackage

[src/dtw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module dtw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;
endmodule

[src/der_tlv_header_walker_unit.sv]
// Top level of the DER TLV header walker: header decode, result register,
// pop sequencer. Depends on dtw_pkg, dtw_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "der_tlv_header_walker_unit_macros.svh"
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------
//  in      | in_valid / in_stall    | in_data_byte, in_start_of_blob
//  out     | out_valid / out_stall  | tag, class, lengths, depth, offset,..
//  cfg     | cfg_wr_en              | cfg_wr_data (blob length)
//
// One byte is decoded in the cycle of its transfer. When the walk offset
// moves to a new element, stack levels ending there are popped: each level
// checked takes a registered read of the end-offset RAM (C_POPA), then a
// compare against the new offset (C_POPB).
// Reset (synchronous, active low) clears control; the end-offset RAM is not
// cleared, only pushed entries are ever read.
// The input is stalled while popping, and while a result waits under out_stall.
module der_tlv_header_walker_unit #(
  parameter int STACK_DEPTH = dtw_pkg::DefStackDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_of_blob,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [27:0] out_tag_number,
  output logic [1:0]  out_tag_class,
  output logic        out_is_constructed,
  output logic [7:0]  out_first_id_octet,
  output logic [30:0] out_content_length,
  output logic [3:0]  out_header_length,
  output logic [2:0]  out_nest_depth,
  output logic [31:0] out_element_offset,
  output dtw_pkg::dtw_status_t out_status
);
  import dtw_pkg::*;

  localparam int DW = $clog2(STACK_DEPTH);
  localparam logic [DW:0] SdW = (DW+1)'(STACK_DEPTH);

  // walk state
  dtw_phase_t    phase_r, phase_nxt;
  logic [31:0]   blob_r;
  logic [31:0]   off_r, off_nxt;
  logic [31:0]   estart_r, estart_nxt;
  logic [27:0]   tag_r, tag_nxt;
  logic [7:0]    id_r, id_nxt;
  logic [31:0]   len_r, len_nxt;
  logic [2:0]    oleft_r, oleft_nxt;
  logic [3:0]    hcnt_r, hcnt_nxt;
  logic [31:0]   skip_r, skip_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic          halted_r, halted_nxt;
  logic [31:0]   tgt_r, tgt_nxt;
  dtw_ctl_t      ctl_r, ctl_nxt;

  // result register
  logic          out_valid_r;
  logic [27:0]   o_tag_r;
  logic [7:0]    o_id_r;
  logic [30:0]   o_len_r;
  logic [3:0]    o_hcnt_r;
  logic [2:0]    o_depth_r;
  logic [31:0]   o_off_r;
  dtw_status_t   o_st_r;

  logic          accept;
  logic          res_v;
  dtw_status_t   res_st;
  logic          pop_go;
  logic          push_en;
  logic [31:0]   push_data;
  logic [31:0]   rd_data;
  logic          pop_hit;

  assign accept = in_valid && !in_stall;

  dtw_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
    .clk     (clk),
    .wr_en   (push_en),
    .wr_addr (depth_nxt),
    .wr_data (push_data),
    .rd_addr (depth_r),
    .rd_data (rd_data)
  );

  // byte decode
  always_comb begin
    logic        fail_v;
    dtw_status_t fail_st;
    logic        do_need;
    logic        do_fin;
    logic        do_adv;
    logic [31:0] adv_to;
    logic [32:0] total;
    logic [32:0] room;
    logic [31:0] next_hdr;
    phase_nxt  = phase_r;
    off_nxt    = off_r;
    estart_nxt = estart_r;
    tag_nxt    = tag_r;
    id_nxt     = id_r;
    len_nxt    = len_r;
    oleft_nxt  = oleft_r;
    hcnt_nxt   = hcnt_r;
    skip_nxt   = skip_r;
    depth_nxt  = depth_r;
    halted_nxt = halted_r;
    tgt_nxt    = tgt_r;
    res_v      = 1'b0;
    res_st     = ST_OK;
    pop_go     = 1'b0;
    push_en    = 1'b0;
    push_data  = '0;
    fail_v     = 1'b0;
    fail_st    = ST_OK;
    do_need    = 1'b0;
    do_fin     = 1'b0;
    do_adv     = 1'b0;
    adv_to     = '0;
    total      = '0;
    room       = '0;
    next_hdr   = '0;

    if (ctl_r == C_POPB && pop_hit) begin
      depth_nxt = depth_r - 1'b1;
    end

    if (accept) begin
      if (in_start_of_blob) begin
        halted_nxt = 1'b0;
        off_nxt    = '0;
        depth_nxt  = '0;
        phase_nxt  = P_ID;
      end
      if (!(halted_nxt || phase_nxt == P_IDLE)) begin
        unique case (phase_nxt)
          P_ID: begin
            estart_nxt = off_nxt;
            id_nxt     = in_data_byte;
            tag_nxt    = '0;
            len_nxt    = '0;
            hcnt_nxt   = '0;
            if (off_nxt >= blob_r) begin
              fail_v  = 1'b1;
              fail_st = ST_TRUNC;
            end else begin
              hcnt_nxt = 4'd1;
              off_nxt  = off_nxt + 32'd1;
              if (in_data_byte[4:0] == HighTagMark) begin
                oleft_nxt = '0;
                phase_nxt = P_TAG;
              end else begin
                tag_nxt   = {22'd0, in_data_byte[5:0]};
                phase_nxt = P_LEN;
              end
              do_need = 1'b1;
            end
          end
          P_TAG: begin
            if (oleft_nxt >= 3'd4) begin
              fail_v  = 1'b1;
              fail_st = ST_MALFORMED;
            end else begin
              oleft_nxt = oleft_nxt + 3'd1;
              tag_nxt   = {tag_nxt[20:0], in_data_byte[6:0]};
              hcnt_nxt  = hcnt_nxt + 4'd1;
              off_nxt   = off_nxt + 32'd1;
              if (!in_data_byte[7]) begin
                phase_nxt = P_LEN;
              end
              do_need = 1'b1;
            end
          end
          P_LEN: begin
            hcnt_nxt = hcnt_nxt + 4'd1;
            off_nxt  = off_nxt + 32'd1;
            if (!in_data_byte[7]) begin
              len_nxt = {25'd0, in_data_byte[6:0]};
              do_fin  = 1'b1;
            end else if (in_data_byte[6:0] > 7'd4) begin
              fail_v  = 1'b1;
              fail_st = ST_MALFORMED;
            end else if (in_data_byte[6:0] == 7'd0) begin
              len_nxt = '0;
              do_fin  = 1'b1;
            end else begin
              oleft_nxt = in_data_byte[2:0];
              len_nxt   = '0;
              phase_nxt = P_LENX;
              do_need   = 1'b1;
            end
          end
          P_LENX: begin
            len_nxt   = {len_nxt[23:0], in_data_byte};
            hcnt_nxt  = hcnt_nxt + 4'd1;
            off_nxt   = off_nxt + 32'd1;
            oleft_nxt = oleft_nxt - 3'd1;
            if (oleft_nxt == 3'd0) begin
              do_fin = 1'b1;
            end else begin
              do_need = 1'b1;
            end
          end
          P_SKIP: begin
            off_nxt = off_nxt + 32'd1;
            if (skip_nxt != 32'd0) begin
              skip_nxt = skip_nxt - 32'd1;
            end
            if (skip_nxt == 32'd0) begin
              do_adv = 1'b1;
              adv_to = off_nxt;
            end
          end
          default: begin
            phase_nxt = P_IDLE;
          end
        endcase

        if (do_need && off_nxt >= blob_r) begin
          fail_v  = 1'b1;
          fail_st = ST_TRUNC;
        end

        if (do_fin) begin
          total    = {1'b0, len_nxt} + 33'(hcnt_nxt);
          room     = (estart_nxt < blob_r) ? {1'b0, blob_r - estart_nxt} : '0;
          next_hdr = estart_nxt + 32'(hcnt_nxt);
          if (len_nxt[31]) begin
            fail_v  = 1'b1;
            fail_st = ST_MALFORMED;
          end else if (total > room) begin
            fail_v  = 1'b1;
            fail_st = ST_OVERRUN;
          end else if ((tag_nxt[4:0] == TagSequence || tag_nxt[4:0] == TagSet) &&
                       ({1'b0, depth_nxt} + 1'b1 >= SdW)) begin
            fail_v  = 1'b1;
            fail_st = ST_STACK;
          end else begin
            if (tag_nxt[4:0] == TagSequence || tag_nxt[4:0] == TagSet) begin
              depth_nxt = depth_nxt + 1'b1;
              push_en   = 1'b1;
              push_data = 32'(total + 33'(estart_nxt));
            end
            res_v  = 1'b1;
            res_st = ST_OK;
            if (!tag_nxt[5] && len_nxt != 32'd0) begin
              skip_nxt  = len_nxt;
              off_nxt   = next_hdr;
              phase_nxt = P_SKIP;
            end else begin
              do_adv = 1'b1;
              adv_to = next_hdr;
            end
          end
        end

        if (do_adv) begin
          off_nxt   = adv_to;
          tgt_nxt   = adv_to;
          phase_nxt = (adv_to >= blob_r) ? P_IDLE : P_ID;
          pop_go    = (depth_nxt != '0);
        end

        if (fail_v) begin
          halted_nxt = 1'b1;
          phase_nxt  = P_IDLE;
          res_v      = 1'b1;
          res_st     = fail_st;
        end
      end
    end
  end

  // pop sequencer: next state
  always_comb begin
    ctl_nxt = ctl_r;
    unique case (ctl_r)
      C_RUN:   if (accept && pop_go) ctl_nxt = C_POPA;
      C_POPA:  ctl_nxt = C_POPB;
      C_POPB:  ctl_nxt = (pop_hit && depth_r != DW'(1)) ? C_POPA : C_RUN;
      default: ctl_nxt = C_RUN;
    endcase
  end

  // pop sequencer: outputs
  always_comb begin
    pop_hit  = (ctl_r == C_POPB) && (depth_r != '0) && (tgt_r >= rd_data);
    in_stall = (ctl_r != C_RUN) || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r       <= C_RUN;
      phase_r     <= P_IDLE;
      blob_r      <= 32'd1;
      off_r       <= '0;
      estart_r    <= '0;
      tag_r       <= '0;
      id_r        <= '0;
      len_r       <= '0;
      oleft_r     <= '0;
      hcnt_r      <= '0;
      skip_r      <= '0;
      depth_r     <= '0;
      halted_r    <= 1'b0;
      tgt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ctl_r    <= ctl_nxt;
      phase_r  <= phase_nxt;
      off_r    <= off_nxt;
      estart_r <= estart_nxt;
      tag_r    <= tag_nxt;
      id_r     <= id_nxt;
      len_r    <= len_nxt;
      oleft_r  <= oleft_nxt;
      hcnt_r   <= hcnt_nxt;
      skip_r   <= skip_nxt;
      depth_r  <= depth_nxt;
      halted_r <= halted_nxt;
      tgt_r    <= tgt_nxt;
      if (cfg_wr_en) begin
        blob_r <= cfg_wr_data;
      end
      if (res_v) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload: loaded on each result transfer into the register
  always_ff @(posedge clk) begin
    if (res_v) begin
      o_tag_r   <= tag_nxt;
      o_id_r    <= id_nxt;
      o_len_r   <= len_nxt[30:0];
      o_hcnt_r  <= hcnt_nxt;
      o_depth_r <= 3'(depth_nxt);
      o_off_r   <= estart_nxt;
      o_st_r    <= res_st;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_tag_number     = o_tag_r;
  assign out_tag_class      = o_id_r[7:6];
  assign out_is_constructed = o_tag_r[5];
  assign out_first_id_octet = o_id_r;
  assign out_content_length = o_len_r;
  assign out_header_length  = o_hcnt_r;
  assign out_nest_depth     = o_depth_r;
  assign out_element_offset = o_off_r;
  assign out_status         = o_st_r;

  `DTW_ASSERT(a_depth_bound, {1'b0, depth_r} < SdW, "stack depth out of range")
  `DTW_ASSERT_IMP(a_popb_after_popa, ctl_r == C_POPB, $past(ctl_r) == C_POPA, "pop compare without read")
  `DTW_ASSERT_IMP(a_halt_no_pop, halted_r, ctl_r == C_RUN, "popping after a halt")
  `DTW_ASSERT_IMP(a_pop_nonzero, ctl_r == C_POPA, depth_r != '0, "pop at depth zero")
endmodule

[verif/der_tlv_header_walker_unit_test.sv]
// Self-checking testbench for der_tlv_header_walker_unit: directed table, then random DER blobs.
// Holds its own model of the header walk. Depends on dtw_pkg and the RTL top level only.
`timescale 1ns / 1ps
module der_tlv_header_walker_unit_test;
  import dtw_pkg::*;

  localparam int StackLevels = DefStackDepth;
  localparam int ItemTarget  = 1050;
  localparam int IdleLimit   = 5000;   // cycles with no transfer before giving up
  localparam int SettleCycles = 40;    // covers a full pop sequence with margin

  // One decoded element header, as it leaves the result channel.
  typedef struct packed {
    logic [27:0] tag;
    logic [1:0]  cls;
    logic        cons;
    logic [7:0]  first;
    logic [30:0] clen;
    logic [3:0]  hlen;
    logic [2:0]  depth;
    logic [31:0] off;
    dtw_status_t st;
  } hdr_t;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  // Directed row: a byte transfer (val[7:0]) or a blob length write (val).
  typedef struct packed {
    row_kind_t   kind;
    logic [31:0] val;
    logic        sob;
    logic        has_exp;
    hdr_t        exp;
  } dir_row_t;

  localparam hdr_t NoHdr = '0;
  localparam int   NumRows = 30;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        in_start_of_blob = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [27:0] out_tag_number;
  logic [1:0]  out_tag_class;
  logic        out_is_constructed;
  logic [7:0]  out_first_id_octet;
  logic [30:0] out_content_length;
  logic [3:0]  out_header_length;
  logic [2:0]  out_nest_depth;
  logic [31:0] out_element_offset;
  dtw_status_t out_status;

  der_tlv_header_walker_unit DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_start_of_blob   (in_start_of_blob),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_tag_number     (out_tag_number),
    .out_tag_class      (out_tag_class),
    .out_is_constructed (out_is_constructed),
    .out_first_id_octet (out_first_id_octet),
    .out_content_length (out_content_length),
    .out_header_length  (out_header_length),
    .out_nest_depth     (out_nest_depth),
    .out_element_offset (out_element_offset),
    .out_status         (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Walker model state. Mirrors the block's state after each byte transfer.
  // ---------------------------------------------------------------------
  logic [31:0] walk_len = 32'd1;
  dtw_phase_t  walk_ph = P_IDLE;
  logic [31:0] walk_off = '0;
  logic [31:0] elem_start = '0;
  logic [27:0] tag_acc = '0;
  logic [7:0]  id_hold = '0;
  logic [31:0] len_acc = '0;
  int          oct_left = 0;
  int          hdr_cnt = 0;
  logic [31:0] skip_left = '0;
  int          cur_depth = 0;
  logic [31:0] end_stack [0:StackLevels-1];
  bit          walk_halted = 1'b0;

  hdr_t hdr_expect_q[$];
  int   n_errors = 0;
  int   n_items = 0;
  int   n_headers = 0;
  int   n_faults = 0;
  int   n_phases = 0;
  bit   burst_mode = 1'b0;

  task automatic emit_hdr(input dtw_status_t st);
    hdr_t h;
    h.tag   = tag_acc;
    h.cls   = id_hold[7:6];
    h.cons  = tag_acc[5];
    h.first = id_hold;
    h.clen  = len_acc[30:0];
    h.hlen  = hdr_cnt[3:0];
    h.depth = cur_depth[2:0];
    h.off   = elem_start;
    h.st    = st;
    hdr_expect_q.push_back(h);
  endtask

  task automatic halt_walk(input dtw_status_t st);
    walk_halted = 1'b1;
    walk_ph = P_IDLE;
    emit_hdr(st);
  endtask

  // Move to the next element; pop every level whose end has been reached.
  task automatic step_to(input logic [31:0] nxt);
    walk_off = nxt;
    while (cur_depth > 0 && cur_depth < StackLevels && nxt >= end_stack[cur_depth])
      cur_depth--;
    walk_ph = (nxt >= walk_len) ? P_IDLE : P_ID;
  endtask

  task automatic check_more;
    if (walk_off >= walk_len) halt_walk(ST_TRUNC);
  endtask

  task automatic close_header;
    longint unsigned tot, room, nxt;
    tot  = longint'(len_acc) + longint'(hdr_cnt);
    room = (elem_start < walk_len) ? longint'(walk_len - elem_start) : 0;
    nxt  = longint'(elem_start) + longint'(hdr_cnt);
    if (len_acc > 32'h7fff_ffff) begin
      halt_walk(ST_MALFORMED);
    end else if (tot > room) begin
      halt_walk(ST_OVERRUN);
    end else if ((tag_acc[4:0] == TagSequence || tag_acc[4:0] == TagSet) &&
                 cur_depth + 1 >= StackLevels) begin
      halt_walk(ST_STACK);
    end else begin
      if (tag_acc[4:0] == TagSequence || tag_acc[4:0] == TagSet) begin
        cur_depth++;
        end_stack[cur_depth] = elem_start + tot[31:0];
      end
      emit_hdr(ST_OK);
      // primitive with content: skip it; otherwise the next header follows
      if (!tag_acc[5] && len_acc != 0) begin
        skip_left = len_acc;
        walk_off = nxt[31:0];
        walk_ph = P_SKIP;
      end else begin
        step_to(nxt[31:0]);
      end
    end
  endtask

  // Advance the model by one accepted byte; used is low when it was ignored.
  task automatic walk_byte(input logic [7:0] b, input logic sob, output bit used);
    int n;
    used = 1'b0;
    if (sob) begin
      walk_halted = 1'b0;
      walk_off = '0;
      cur_depth = 0;
      walk_ph = P_ID;
    end
    if (walk_halted || walk_ph == P_IDLE) return;
    used = 1'b1;
    case (walk_ph)
      P_ID: begin
        elem_start = walk_off;
        id_hold = b;
        tag_acc = '0;
        len_acc = '0;
        hdr_cnt = 0;
        if (walk_off >= walk_len) begin
          halt_walk(ST_TRUNC);
        end else begin
          hdr_cnt = 1;
          walk_off++;
          if (b[4:0] == HighTagMark) begin
            oct_left = 0;
            walk_ph = P_TAG;
          end else begin
            tag_acc = {22'd0, b[5:0]};
            walk_ph = P_LEN;
          end
          check_more();
        end
      end
      P_TAG: begin
        if (oct_left >= 4) begin
          halt_walk(ST_MALFORMED);
        end else begin
          oct_left++;
          tag_acc = {tag_acc[20:0], b[6:0]};
          hdr_cnt++;
          walk_off++;
          if (!b[7]) walk_ph = P_LEN;
          check_more();
        end
      end
      P_LEN: begin
        hdr_cnt++;
        walk_off++;
        n = b[6:0];
        if (!b[7]) begin
          len_acc = {25'd0, b[6:0]};
          close_header();
        end else if (n > 4) begin
          halt_walk(ST_MALFORMED);
        end else if (n == 0) begin
          len_acc = '0;   // indefinite marker taken as zero length
          close_header();
        end else begin
          oct_left = n;
          len_acc = '0;
          walk_ph = P_LENX;
          check_more();
        end
      end
      P_LENX: begin
        len_acc = {len_acc[23:0], b};
        hdr_cnt++;
        walk_off++;
        oct_left--;
        if (oct_left == 0) close_header();
        else check_more();
      end
      P_SKIP: begin
        walk_off++;
        if (skip_left > 0) skip_left--;
        if (skip_left == 0) step_to(walk_off);
      end
      default: walk_ph = P_IDLE;
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Result checking: field by field against the oldest expectation.
  // ---------------------------------------------------------------------
  task automatic cmp_field(input string nm, input longint unsigned e, input longint unsigned a);
    if (e != a) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, nm, e, a);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    hdr_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (hdr_expect_q.size() == 0) begin
        $display("%0t ns: unexpected result, tag 0x%0h offset %0d status %0d",
                 $time, out_tag_number, out_element_offset, out_status);
        n_errors++;
      end else begin
        e = hdr_expect_q.pop_front();
        cmp_field("tag_number", e.tag, out_tag_number);
        cmp_field("tag_class", e.cls, out_tag_class);
        cmp_field("is_constructed", e.cons, out_is_constructed);
        cmp_field("first_id_octet", e.first, out_first_id_octet);
        cmp_field("content_length", e.clen, out_content_length);
        cmp_field("header_length", e.hlen, out_header_length);
        cmp_field("nest_depth", e.depth, out_nest_depth);
        cmp_field("element_offset", e.off, out_element_offset);
        cmp_field("status", e.st, out_status);
        if (e.st == ST_OK) n_headers++;
        else n_faults++;
      end
    end
  end

  // Watchdog: any transfer, register write or reset clears it.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("%0t ns: no transfer for %0d cycles", $time, IdleLimit);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // Receiver back-pressure: stall or release for a random run of cycles.
  int stall_hold = 0;
  always @(negedge clk) begin
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      stall_hold <= $urandom_range(0, 1) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    end else begin
      out_stall <= ($urandom_range(0, 1) == 1);
      stall_hold <= pick_gap();
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  // One byte transfer; starts and ends at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic sob, output bit used);
    int g;
    g = burst_mode ? 0 : pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_start_of_blob <= sob;
    do @(posedge clk); while (in_stall);
    walk_byte(b, sob, used);
    n_items++;
    @(negedge clk);
  endtask

  // Quiesce, let any pop sequence finish, then write the blob length.
  task automatic set_walk_len(input logic [31:0] v);
    in_valid <= 1'b0;
    while (hdr_expect_q.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    walk_len = v;
    n_phases++;
  endtask

  // Append one random TLV element; constructed ones nest further elements.
  function automatic void gen_elem(ref logic [7:0] q[$], input int lvl);
    logic [7:0] body[$];
    logic [7:0] id;
    int n_oct, len, r, k;
    r = $urandom_range(0, 99);
    if (lvl < 10 && r < 55 - 4 * lvl) begin
      k = $urandom_range(0, 3);
      case ($urandom_range(0, 2))
        0: id = 8'h30;
        1: id = 8'h31;
        default: id = {2'($urandom), 1'b1, 5'($urandom_range(0, 30))};
      endcase
      repeat (k) gen_elem(body, lvl + 1);
    end else begin
      id = {2'($urandom), 1'b0, 5'($urandom_range(0, 30))};
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 24) : $urandom_range(0, 5);
      repeat (len) body.push_back(8'($urandom));
    end
    // high-tag form now and then, rarely with one octet too many
    if ($urandom_range(0, 9) == 0) begin
      n_oct = ($urandom_range(0, 19) == 0) ? 5 : $urandom_range(1, 4);
      q.push_back(id | 8'h1f);
      for (int i = 0; i < n_oct; i++) q.push_back({i != n_oct - 1, 7'($urandom)});
    end else begin
      q.push_back(id);
    end
    len = body.size();
    r = $urandom_range(0, 99);
    if (r < 3) begin
      // broken length field
      case ($urandom_range(0, 2))
        0: q.push_back(8'h85);
        1: begin
          q.push_back(8'h84);
          q.push_back(8'h80 | 8'($urandom));
          repeat (3) q.push_back(8'($urandom));
        end
        default: q.push_back(8'($urandom_range(0, 127)));
      endcase
    end else if (len < 128 && r < 70) begin
      q.push_back(len == 0 && r < 12 ? 8'h80 : 8'(len));
    end else if (len < 256 && r < 80) begin
      q.push_back(8'h81);
      q.push_back(8'(len));
    end else if (r < 90) begin
      q.push_back(8'h82);
      q.push_back(8'(len >> 8));
      q.push_back(8'(len));
    end else begin
      q.push_back(8'h84);
      q.push_back(8'h00);
      q.push_back(8'h00);
      q.push_back(8'(len >> 8));
      q.push_back(8'(len));
    end
    foreach (body[i]) q.push_back(body[i]);
  endfunction

  // Directed rows: extremes, both identifier and length forms, truncation, malformed and overrun errors.
  dir_row_t dir_tab [0:NumRows-1] = '{
    // reset length is 1: a lone identifier is truncated
    '{ROW_BYTE, 32'h05, 1'b1, 1'b1, '{28'h5, 2'd0, 1'b0, 8'h05, 31'd0, 4'd1, 3'd0, 32'd0, ST_TRUNC}},
    '{ROW_BYTE, 32'h00, 1'b0, 1'b0, NoHdr},                // halted: ignored
    '{ROW_CFG,  32'd40, 1'b0, 1'b0, NoHdr},
    // SEQUENCE of 13 bytes pushes one level
    '{ROW_BYTE, 32'h30, 1'b1, 1'b0, NoHdr},
    '{ROW_BYTE, 32'h0d, 1'b0, 1'b1, '{28'h30, 2'd0, 1'b1, 8'h30, 31'd13, 4'd2, 3'd1, 32'd0, ST_OK}},
    '{ROW_BYTE, 32'h02, 1'b0, 1'b0, NoHdr},                // INTEGER, one content byte
    '{ROW_BYTE, 32'h01, 1'b0, 1'b0, NoHdr},
    '{ROW_BYTE, 32'hff, 1'b0, 1'b0, NoHdr},
    '{ROW_BYTE, 32'hdf, 1'b0, 1'b0, NoHdr},                // private, high tag, zero length
    '{ROW_BYTE, 32'h81, 1'b0, 1'b0, NoHdr},
    '{ROW_BYTE, 32'h00, 1'b0, 1'b0, NoHdr},
    '{ROW_BYTE, 32'h80, 1'b0, 1'b0, NoHdr},
    '{ROW_BYTE, 32'h04, 1'b0, 1'b0, NoHdr},                // long-form length of 2
    '{ROW_BYTE, 32'h82, 1'b0, 1'b0, NoHdr},
    '{ROW_BYTE, 32'h00, 1'b0, 1'b0, NoHdr},
    '{ROW_BYTE, 32'h02, 1'b0, 1'b0, NoHdr},
    '{ROW_BYTE, 32'haa, 1'b0, 1'b0, NoHdr},
    '{ROW_BYTE, 32'hbb, 1'b0, 1'b0, NoHdr},                // SEQUENCE level ends here
    '{ROW_BYTE, 32'h1f, 1'b0, 1'b0, NoHdr},                // high tag with five octets
    '{ROW_BYTE, 32'h81, 1'b0, 1'b0, NoHdr},
    '{ROW_BYTE, 32'h81, 1'b0, 1'b0, NoHdr},
    '{ROW_BYTE, 32'h81, 1'b0, 1'b0, NoHdr},
    '{ROW_BYTE, 32'h81, 1'b0, 1'b0, NoHdr},
    '{ROW_BYTE, 32'h81, 1'b0, 1'b0, NoHdr},
    // five length octets
    '{ROW_BYTE, 32'h04, 1'b1, 1'b0, NoHdr},
    '{ROW_BYTE, 32'h85, 1'b0, 1'b1, '{28'h4, 2'd0, 1'b0, 8'h04, 31'd0, 4'd2, 3'd0, 32'd0, ST_MALFORMED}},
    // content runs past the blob end
    '{ROW_BYTE, 32'h04, 1'b1, 1'b0, NoHdr},
    '{ROW_BYTE, 32'h7f, 1'b0, 1'b1, '{28'h4, 2'd0, 1'b0, 8'h04, 31'd127, 4'd2, 3'd0, 32'd0, ST_OVERRUN}},
    // tail bytes after the halt are ignored
    '{ROW_BYTE, 32'hff, 1'b0, 1'b0, NoHdr},
    '{ROW_BYTE, 32'hff, 1'b0, 1'b0, NoHdr}
  };

  initial begin
    logic [7:0] blob[$];
    logic [31:0] len;
    int   qn, r;
    bit   used;
    foreach (end_stack[i]) end_stack[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: typed-in expectations replace the model's where given.
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        set_walk_len(dir_tab[i].val);
      end else begin
        qn = hdr_expect_q.size();
        send_byte(dir_tab[i].val[7:0], dir_tab[i].sob, used);
        if (dir_tab[i].has_exp) begin
          if (hdr_expect_q.size() > qn) hdr_expect_q[hdr_expect_q.size() - 1] = dir_tab[i].exp;
          else hdr_expect_q.push_back(dir_tab[i].exp);
        end
      end
    end

    // Random part: each phase sets a blob length then walks a few blobs.
    while (n_items < ItemTarget) begin
      r = $urandom_range(0, 99);
      if (r < 8) len = 32'd1;
      else if (r < 16) len = 32'd2;
      else if (r < 24) len = 32'hffff_ffff;
      else if (r < 28) len = 32'h8000_0000;
      else len = $urandom_range(3, 150);
      set_walk_len(len);
      burst_mode = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 3)) begin
        blob.delete();
        if (len <= 1000) begin
          while (blob.size() < len) gen_elem(blob, 0);
          if ($urandom_range(0, 3) != 0) blob = blob[0:len-1];   // else tail bytes follow
        end else begin
          repeat ($urandom_range(1, 3)) gen_elem(blob, 0);
        end
        r = $urandom_range(0, 99);
        if (r < 8) begin
          // pure noise
          blob.delete();
          repeat ($urandom_range(1, 30)) blob.push_back(8'($urandom));
        end else if (r < 16) begin
          blob[$urandom_range(0, blob.size() - 1)] = 8'($urandom);
        end
        foreach (blob[i])
          send_byte(blob[i], i == 0 || $urandom_range(0, 199) == 0, used);
      end
    end

    // Drain, then let the block settle before the verdict.
    in_valid <= 1'b0;
    while (hdr_expect_q.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);

    $display("Sent %0d bytes over %0d blob-length settings.", n_items, n_phases);
    $display("Checked %0d good headers and %0d error results.", n_headers, n_faults);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
